// File: sv/assert_macros.svh
// assertion macros for the drive mixer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define OWDM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define OWDM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/owdm_pkg.sv
// package: drive term codes, mixing tables and constants for the drive mixer
`timescale 1ns / 1ps

package owdm_pkg;

  localparam int MAX_CMD    = 100;
  localparam int Q_BITS     = 7;
  localparam int Q_SPLIT    = 3;
  localparam int NUM_WHEELS = 4;
  localparam int DUTY_SHIFT = 19;
  localparam logic [20:0] DUTY_RECIP = 21'd1336965;

  typedef enum logic [1:0] {
    TERM_NONE = 2'd0,
    TERM_ROT  = 2'd1,
    TERM_POS  = 2'd2,
    TERM_NEG  = 2'd3
  } term_t;

  typedef term_t [NUM_WHEELS-1:0] term_row_t;

  function automatic term_row_t mix_row(input logic four, input logic [3:0] code);
    term_row_t row;
    row = {TERM_NONE, TERM_NONE, TERM_NONE, TERM_NONE};
    if (four) begin
      unique case (code)
        4'd0:    row = {TERM_NEG, TERM_POS, TERM_POS, TERM_NEG};
        4'd1:    row = {TERM_NEG, TERM_POS, TERM_ROT, TERM_ROT};
        4'd2:    row = {TERM_NEG, TERM_POS, TERM_NEG, TERM_POS};
        4'd3:    row = {TERM_ROT, TERM_ROT, TERM_NEG, TERM_POS};
        4'd4:    row = {TERM_POS, TERM_NEG, TERM_NEG, TERM_POS};
        4'd13:   row = {TERM_POS, TERM_NEG, TERM_ROT, TERM_ROT};
        4'd14:   row = {TERM_POS, TERM_NEG, TERM_POS, TERM_NEG};
        4'd15:   row = {TERM_ROT, TERM_ROT, TERM_POS, TERM_NEG};
        default: row = {TERM_NONE, TERM_NONE, TERM_NONE, TERM_NONE};
      endcase
    end else begin
      unique case (code)
        4'd0:    row = {TERM_NONE, TERM_POS, TERM_ROT, TERM_NEG};
        4'd1:    row = {TERM_NONE, TERM_POS, TERM_NEG, TERM_ROT};
        4'd2:    row = {TERM_NONE, TERM_ROT, TERM_NEG, TERM_POS};
        4'd3:    row = {TERM_NONE, TERM_NEG, TERM_ROT, TERM_POS};
        4'd14:   row = {TERM_NONE, TERM_NEG, TERM_POS, TERM_ROT};
        4'd15:   row = {TERM_NONE, TERM_ROT, TERM_POS, TERM_NEG};
        default: row = {TERM_NONE, TERM_NONE, TERM_NONE, TERM_NONE};
      endcase
    end
    return row;
  endfunction

endpackage

// File: sv/omni_wheel_drive_mixer.sv
// Throughput: one command per cycle while in_stall is low; the six-stage pipeline
// (magnitude, scale by 100, two stages of restoring division, wheel mixing, duty multiply)
// holds as a whole on a stall.
// Reset: synchronous, active low; clears every stage valid bit and sets wheel_count to 4.
// cfg_ready is always high; a written wheel_count applies to commands accepted afterwards.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module omni_wheel_drive_mixer
  import owdm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_wheel_count,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic signed [3:0] in_heading_code,
  input  logic signed [8:0] in_travel_speed,
  input  logic signed [8:0] in_rotation,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [3:0]        out_update_mask,
  output logic              out_dir_m1,
  output logic [7:0]        out_duty_m1,
  output logic              out_dir_m2,
  output logic [7:0]        out_duty_m2,
  output logic              out_dir_m3,
  output logic [7:0]        out_duty_m3,
  output logic              out_dir_m4,
  output logic [7:0]        out_duty_m4
);

  logic [2:0] wheel_count_r;
  logic       advance;

  // stage 1: magnitudes and total
  logic        s1_valid_r, s1_four_r, s1_spd_neg_r, s1_rot_neg_r;
  logic [3:0]  s1_code_r;
  logic [8:0]  s1_spd_mag_r, s1_rot_mag_r;
  logic [9:0]  s1_total_r;
  logic [8:0]  in_spd_mag, in_rot_mag;

  // stage 2: numerators
  logic        s2_valid_r, s2_four_r, s2_spd_neg_r, s2_rot_neg_r, s2_scale_r;
  logic [3:0]  s2_code_r;
  logic [6:0]  s2_spd_raw_r, s2_rot_raw_r;
  logic [9:0]  s2_total_r;
  logic [14:0] s2_spd_num_r, s2_rot_num_r;

  // stage 3: upper quotient bits
  logic        s3_valid_r, s3_four_r, s3_spd_neg_r, s3_rot_neg_r, s3_scale_r;
  logic [3:0]  s3_code_r;
  logic [6:0]  s3_spd_raw_r, s3_rot_raw_r;
  logic [9:0]  s3_total_r;
  logic [14:0] s3_spd_rem_r, s3_rot_rem_r;
  logic [14:0] s3_spd_rem_nxt, s3_rot_rem_nxt;
  logic [Q_BITS-Q_SPLIT-1:0] s3_spd_q_r, s3_rot_q_r, s3_spd_q_nxt, s3_rot_q_nxt;

  // stage 4: signed scaled speed and rotation
  logic              s4_valid_r, s4_four_r;
  logic [3:0]        s4_code_r;
  logic signed [7:0] s4_spd_r, s4_rot_r, s4_spd_nxt, s4_rot_nxt;
  logic [Q_SPLIT-1:0] s4_spd_qlo, s4_rot_qlo;

  // stage 5: per wheel direction and clamped magnitude
  logic       s5_valid_r;
  logic [3:0] s5_mask_r, s5_mask_nxt;
  logic [3:0] s5_dir_r, s5_dir_nxt;
  logic [6:0] s5_mag_r [NUM_WHEELS];
  logic [6:0] s5_mag_nxt [NUM_WHEELS];

  // output stage
  logic       out_valid_r;
  logic [3:0] out_mask_r;
  logic [3:0] out_dir_r;
  logic [7:0] out_duty_r [NUM_WHEELS];

  assign cfg_ready = 1'b1;
  assign advance   = !(out_valid_r && out_stall);
  assign in_stall  = !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wheel_count_r <= 3'd4;
    end else if (cfg_valid && cfg_ready) begin
      wheel_count_r <= cfg_wheel_count;
    end
  end

  assign in_spd_mag = in_travel_speed[8] ? (~$unsigned(in_travel_speed) + 9'd1)
                                         : $unsigned(in_travel_speed);
  assign in_rot_mag = in_rotation[8] ? (~$unsigned(in_rotation) + 9'd1)
                                     : $unsigned(in_rotation);

  // restoring division, quotient bits 6 down to 3
  always_comb begin
    logic [15:0] dsh;
    s3_spd_rem_nxt = s2_spd_num_r;
    s3_rot_rem_nxt = s2_rot_num_r;
    s3_spd_q_nxt   = '0;
    s3_rot_q_nxt   = '0;
    for (int k = Q_BITS - 1; k >= Q_SPLIT; k--) begin
      dsh = 16'(s2_total_r) << k;
      if ({1'b0, s3_spd_rem_nxt} >= dsh) begin
        s3_spd_rem_nxt = s3_spd_rem_nxt - dsh[14:0];
        s3_spd_q_nxt[k-Q_SPLIT] = 1'b1;
      end
      if ({1'b0, s3_rot_rem_nxt} >= dsh) begin
        s3_rot_rem_nxt = s3_rot_rem_nxt - dsh[14:0];
        s3_rot_q_nxt[k-Q_SPLIT] = 1'b1;
      end
    end
  end

  // quotient bits 2 down to 0, then sign and selection
  always_comb begin
    logic [15:0] dsh;
    logic [14:0] spd_rem, rot_rem;
    logic [6:0]  spd_m, rot_m;
    spd_rem    = s3_spd_rem_r;
    rot_rem    = s3_rot_rem_r;
    s4_spd_qlo = '0;
    s4_rot_qlo = '0;
    for (int k = Q_SPLIT - 1; k >= 0; k--) begin
      dsh = 16'(s3_total_r) << k;
      if ({1'b0, spd_rem} >= dsh) begin
        spd_rem = spd_rem - dsh[14:0];
        s4_spd_qlo[k] = 1'b1;
      end
      if ({1'b0, rot_rem} >= dsh) begin
        rot_rem = rot_rem - dsh[14:0];
        s4_rot_qlo[k] = 1'b1;
      end
    end
    spd_m = s3_scale_r ? {s3_spd_q_r, s4_spd_qlo} : s3_spd_raw_r;
    rot_m = s3_scale_r ? {s3_rot_q_r, s4_rot_qlo} : s3_rot_raw_r;
    s4_spd_nxt = s3_spd_neg_r ? -$signed({1'b0, spd_m}) : $signed({1'b0, spd_m});
    s4_rot_nxt = s3_rot_neg_r ? -$signed({1'b0, rot_m}) : $signed({1'b0, rot_m});
  end

  // wheel mixing and clamp
  always_comb begin
    term_row_t         row;
    logic signed [8:0] sum;
    logic signed [8:0] clamped;
    row = mix_row(s4_four_r, s4_code_r);
    for (int i = 0; i < NUM_WHEELS; i++) begin
      unique case (row[i])
        TERM_POS: sum = 9'(s4_spd_r) + 9'(s4_rot_r);
        TERM_NEG: sum = 9'(s4_rot_r) - 9'(s4_spd_r);
        TERM_ROT: sum = 9'(s4_rot_r);
        default:  sum = '0;
      endcase
      if (sum > 9'sd100) begin
        clamped = 9'sd100;
      end else if (sum < -9'sd100) begin
        clamped = -9'sd100;
      end else begin
        clamped = sum;
      end
      s5_mask_nxt[i] = (row[i] != TERM_NONE);
      s5_dir_nxt[i]  = s5_mask_nxt[i] && !clamped[8];
      s5_mag_nxt[i]  = !s5_mask_nxt[i] ? 7'd0
                     : clamped[8] ? 7'(-clamped) : clamped[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      s5_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r  <= in_valid;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      s5_valid_r  <= s4_valid_r;
      out_valid_r <= s5_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_code_r    <= $unsigned(in_heading_code);
      s1_four_r    <= wheel_count_r[2];
      s1_spd_neg_r <= in_travel_speed[8];
      s1_rot_neg_r <= in_rotation[8];
      s1_spd_mag_r <= in_spd_mag;
      s1_rot_mag_r <= in_rot_mag;
      s1_total_r   <= {1'b0, in_spd_mag} + {1'b0, in_rot_mag};

      s2_code_r    <= s1_code_r;
      s2_four_r    <= s1_four_r;
      s2_spd_neg_r <= s1_spd_neg_r;
      s2_rot_neg_r <= s1_rot_neg_r;
      s2_scale_r   <= (s1_total_r > 10'(MAX_CMD));
      s2_spd_raw_r <= s1_spd_mag_r[6:0];
      s2_rot_raw_r <= s1_rot_mag_r[6:0];
      s2_total_r   <= s1_total_r;
      s2_spd_num_r <= 15'(s1_spd_mag_r * 15'(MAX_CMD));
      s2_rot_num_r <= 15'(s1_rot_mag_r * 15'(MAX_CMD));

      s3_code_r    <= s2_code_r;
      s3_four_r    <= s2_four_r;
      s3_spd_neg_r <= s2_spd_neg_r;
      s3_rot_neg_r <= s2_rot_neg_r;
      s3_scale_r   <= s2_scale_r;
      s3_spd_raw_r <= s2_spd_raw_r;
      s3_rot_raw_r <= s2_rot_raw_r;
      s3_total_r   <= s2_total_r;
      s3_spd_rem_r <= s3_spd_rem_nxt;
      s3_rot_rem_r <= s3_rot_rem_nxt;
      s3_spd_q_r   <= s3_spd_q_nxt;
      s3_rot_q_r   <= s3_rot_q_nxt;

      s4_code_r    <= s3_code_r;
      s4_four_r    <= s3_four_r;
      s4_spd_r     <= s4_spd_nxt;
      s4_rot_r     <= s4_rot_nxt;

      s5_mask_r    <= s5_mask_nxt;
      s5_dir_r     <= s5_dir_nxt;
      for (int i = 0; i < NUM_WHEELS; i++) begin
        s5_mag_r[i]   <= s5_mag_nxt[i];
        out_duty_r[i] <= 8'((28'(s5_mag_r[i]) * 28'(DUTY_RECIP)) >> DUTY_SHIFT);
      end

      out_mask_r   <= s5_mask_r;
      out_dir_r    <= s5_dir_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_update_mask = out_mask_r;
  assign out_dir_m1      = out_dir_r[0];
  assign out_duty_m1     = out_duty_r[0];
  assign out_dir_m2      = out_dir_r[1];
  assign out_duty_m2     = out_duty_r[1];
  assign out_dir_m3      = out_dir_r[2];
  assign out_duty_m3     = out_duty_r[2];
  assign out_dir_m4      = out_dir_r[3];
  assign out_duty_m4     = out_duty_r[3];

  `OWDM_ASSERT(a_mask_all_or_none, out_valid_r |-> (out_mask_r == 4'd0 || out_mask_r == 4'd7 || out_mask_r == 4'd15), "update mask is neither empty nor a full wheel set")
  `OWDM_ASSERT(a_unwritten_m4_zero, (out_valid_r && !out_mask_r[3]) |-> (out_duty_r[3] == 8'd0 && !out_dir_r[3]), "motor 4 carries a command without its mask bit")
  `OWDM_ASSERT(a_pipe_holds, (s5_valid_r && !advance) |=> s5_valid_r, "pipeline beat lost during a stall")
  `OWDM_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid_r, "result valid right after reset")

endmodule
